### rtl/pcc_pkg.sv
package pcc_pkg;

  localparam int DEPTH_DEFAULT = 4;

  localparam int POS_W      = 24;
  localparam int SUM_W      = POS_W + 1;
  localparam int CNT_W      = 3;
  localparam int FRAC_W     = 8;
  localparam int QUOT_W     = CNT_W + FRAC_W;
  localparam int STEP_W     = 5;
  localparam int CHAN_W     = 8;
  localparam int WORD_W     = 32;
  localparam int ELAPSED_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [POS_W-1:0] PERIOD_RESET = POS_W'(3000);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL3   = 3'd5;

  // Divider pass lengths: the full sum for the wrap, and only the quotient
  // bits that can be nonzero for the index and fraction.
  localparam logic [STEP_W-1:0] WRAP_STEPS  = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] PHASE_STEPS = STEP_W'(QUOT_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCALE,
    ST_FRAC,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_BLEND
  } state_t;

  typedef struct packed {
    logic              start;
    logic [POS_W-1:0]  init_rem;
    logic [SUM_W-1:0]  init_bits;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [POS_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } div_stat_t;

endpackage

### rtl/pcc_if.sv
interface pcc_tick_if;
  logic                           valid;
  logic                           ready;
  logic [pcc_pkg::ELAPSED_W-1:0] elapsed;

  modport source (output valid, output elapsed, input ready);
  modport sink (input valid, input elapsed, output ready);
endinterface

interface pcc_color_if;
  logic                        valid;
  logic                        ready;
  logic [pcc_pkg::CHAN_W-1:0] red;
  logic [pcc_pkg::CHAN_W-1:0] green;
  logic [pcc_pkg::CHAN_W-1:0] blue;
  logic [pcc_pkg::CHAN_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

### rtl/palette_color_cycle.sv
// Flow: for an accepted tick with a nonzero period, a 25-step wrap of the position and
// an 11-step index/fraction pass on the shared serial divider, then two palette reads
// and the blend produce its color word; at zero period the divider passes are skipped.
// Ticks: a new tick is taken only in idle, after the last one has reached the output
// register; a tick with fewer than two palette entries in use is taken and dropped.
// Reset: synchronous; registers return to period 3000, count 0, entries 0, position 0.
module palette_color_cycle #(
  parameter int PALETTE_DEPTH = pcc_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_data,
  pcc_tick_if.sink                          tick,
  pcc_color_if.source                       color
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  pcc_pkg::state_t state, state_next;

  logic [pcc_pkg::POS_W-1:0]  period;
  logic [pcc_pkg::CNT_W-1:0]  count;
  logic [pcc_pkg::POS_W-1:0]  pos;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           nxt;
  logic [pcc_pkg::FRAC_W-1:0] frac;
  logic [pcc_pkg::WORD_W-1:0] cur_word;
  logic [pcc_pkg::WORD_W-1:0] rd_data;

  logic [pcc_pkg::WORD_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0]   pal_valid;

  logic                       out_valid;
  logic [pcc_pkg::CHAN_W-1:0] out_red, out_green, out_blue, out_alpha;
  logic [pcc_pkg::CHAN_W-1:0] bl_red, bl_green, bl_blue, bl_alpha;

  pcc_pkg::div_cmd_t  div_cmd;
  pcc_pkg::div_stat_t div_stat;

  logic [pcc_pkg::CNT_W-1:0]   eff_count;
  logic                        accept;
  logic                        active;
  logic [pcc_pkg::SUM_W-1:0]   sum;
  logic [pcc_pkg::SUM_W+1:0]   scaled;
  logic [pcc_pkg::CNT_W-1:0]   idx_raw, idx_c, nxt_c;
  logic                        load_out;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [pcc_pkg::CNT_W-1:0]   slot;
  logic                        pal_we;

  assign eff_count = (int'(count) > PALETTE_DEPTH) ? pcc_pkg::CNT_W'(PALETTE_DEPTH) : count;
  assign accept    = tick.valid && tick.ready;
  assign active    = (eff_count >= pcc_pkg::CNT_W'(2));
  assign sum       = {1'b0, pos} + {{(pcc_pkg::SUM_W-pcc_pkg::ELAPSED_W){1'b0}}, tick.elapsed};
  assign scaled    = {3'b000, pos} * {{pcc_pkg::POS_W{1'b0}}, eff_count};

  // The quotient of (scaled << 8) / period holds the index above the fraction.
  always_comb begin
    idx_raw = div_stat.quot[pcc_pkg::QUOT_W-1:pcc_pkg::FRAC_W];
    idx_c   = (idx_raw >= eff_count) ? (eff_count - 1'b1) : idx_raw;
    nxt_c   = ((idx_c + 1'b1) == eff_count) ? '0 : (idx_c + 1'b1);
  end

  // Configuration registers and palette store.
  assign slot   = cfg_index - pcc_pkg::CFG_PAL0;
  assign pal_we = cfg_we && (cfg_index inside {[pcc_pkg::CFG_PAL0:pcc_pkg::CFG_PAL3]})
                  && (int'(slot) < PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= pcc_pkg::PERIOD_RESET;
      count     <= '0;
      pal_valid <= '0;
    end else begin
      if (cfg_we && cfg_index == pcc_pkg::CFG_PERIOD) begin
        period <= cfg_data[pcc_pkg::POS_W-1:0];
      end
      if (cfg_we && cfg_index == pcc_pkg::CFG_COUNT) begin
        count <= cfg_data[pcc_pkg::CNT_W-1:0];
      end
      if (pal_we) begin
        pal_valid[IDX_W'(slot)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[IDX_W'(slot)] <= cfg_data;
    end
  end

  // An entry never written reads as zero.
  assign rd_addr = (state == pcc_pkg::ST_RD_NXT) ? nxt : idx;
  assign rd_en   = (state == pcc_pkg::ST_RD_CUR) || (state == pcc_pkg::ST_RD_NXT);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= pal_valid[rd_addr] ? pal_mem[rd_addr] : '0;
    end
  end

  pcc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .divisor (period),
    .cmd     (div_cmd),
    .stat    (div_stat)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_cmd    = '0;
    load_out   = 1'b0;
    case (state)
      pcc_pkg::ST_IDLE: begin
        if (accept && active) begin
          if (period == '0) begin
            state_next = pcc_pkg::ST_RD_CUR;
          end else begin
            div_cmd.start     = 1'b1;
            div_cmd.init_rem  = '0;
            div_cmd.init_bits = sum;
            div_cmd.steps     = pcc_pkg::WRAP_STEPS;
            state_next        = pcc_pkg::ST_MOD;
          end
        end
      end
      pcc_pkg::ST_MOD: begin
        if (div_stat.done) begin
          state_next = pcc_pkg::ST_SCALE;
        end
      end
      pcc_pkg::ST_SCALE: begin
        div_cmd.start     = 1'b1;
        div_cmd.init_rem  = scaled[pcc_pkg::SUM_W+1:3];
        div_cmd.init_bits = {scaled[2:0], {(pcc_pkg::SUM_W-3){1'b0}}};
        div_cmd.steps     = pcc_pkg::PHASE_STEPS;
        state_next        = pcc_pkg::ST_FRAC;
      end
      pcc_pkg::ST_FRAC: begin
        if (div_stat.done) begin
          state_next = pcc_pkg::ST_RD_CUR;
        end
      end
      pcc_pkg::ST_RD_CUR: begin
        state_next = pcc_pkg::ST_RD_NXT;
      end
      pcc_pkg::ST_RD_NXT: begin
        state_next = pcc_pkg::ST_BLEND;
      end
      pcc_pkg::ST_BLEND: begin
        if (!out_valid || color.ready) begin
          load_out   = 1'b1;
          state_next = pcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcc_pkg::ST_IDLE;
      end
    endcase
  end

  assign tick.ready = (state == pcc_pkg::ST_IDLE);

  // Position and phase registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (state == pcc_pkg::ST_MOD && div_stat.done) begin
      pos <= div_stat.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcc_pkg::ST_IDLE) begin
      idx  <= '0;
      nxt  <= IDX_W'(1);
      frac <= '0;
    end else if (state == pcc_pkg::ST_FRAC && div_stat.done) begin
      idx  <= IDX_W'(idx_c);
      nxt  <= IDX_W'(nxt_c);
      frac <= div_stat.quot[pcc_pkg::FRAC_W-1:0];
    end
    if (state == pcc_pkg::ST_RD_NXT) begin
      cur_word <= rd_data;
    end
  end

  pcc_blend u_red (
    .cur (cur_word[31:24]), .nxt (rd_data[31:24]), .frac (frac), .chan (bl_red)
  );
  pcc_blend u_green (
    .cur (cur_word[23:16]), .nxt (rd_data[23:16]), .frac (frac), .chan (bl_green)
  );
  pcc_blend u_blue (
    .cur (cur_word[15:8]), .nxt (rd_data[15:8]), .frac (frac), .chan (bl_blue)
  );
  pcc_blend u_alpha (
    .cur (cur_word[7:0]), .nxt (rd_data[7:0]), .frac (frac), .chan (bl_alpha)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (color.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red   <= bl_red;
      out_green <= bl_green;
      out_blue  <= bl_blue;
      out_alpha <= bl_alpha;
    end
  end

  assign color.valid = out_valid;
  assign color.red   = out_red;
  assign color.green = out_green;
  assign color.blue  = out_blue;
  assign color.alpha = out_alpha;

endmodule

### rtl/pcc_div.sv
module pcc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [pcc_pkg::POS_W-1:0] divisor,
  input  pcc_pkg::div_cmd_t        cmd,
  output pcc_pkg::div_stat_t       stat
);

  logic [pcc_pkg::POS_W-1:0]  rem;
  logic [pcc_pkg::SUM_W-1:0]  bits;
  logic [pcc_pkg::QUOT_W-1:0] quot;
  logic [pcc_pkg::STEP_W-1:0] cnt;

  logic [pcc_pkg::SUM_W:0]    trial;
  logic                       ge;
  logic [pcc_pkg::POS_W-1:0]  rem_next;

  // One restoring step: shift the next dividend bit in and subtract the
  // divisor when it fits. The partial remainder always stays below it.
  always_comb begin
    trial    = {1'b0, rem, bits[pcc_pkg::SUM_W-1]} - {2'b00, divisor};
    ge       = !trial[pcc_pkg::SUM_W];
    rem_next = ge ? trial[pcc_pkg::POS_W-1:0]
                  : {rem[pcc_pkg::POS_W-2:0], bits[pcc_pkg::SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= cmd.steps;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= cmd.init_rem;
      bits <= cmd.init_bits;
      quot <= '0;
    end else if (cnt != '0) begin
      rem  <= rem_next;
      bits <= {bits[pcc_pkg::SUM_W-2:0], 1'b0};
      quot <= {quot[pcc_pkg::QUOT_W-2:0], ge};
    end
  end

  assign stat.done = (cnt == '0);
  assign stat.rem  = rem;
  assign stat.quot = quot;

endmodule

### rtl/pcc_blend.sv
module pcc_blend (
  input  logic [pcc_pkg::CHAN_W-1:0] cur,
  input  logic [pcc_pkg::CHAN_W-1:0] nxt,
  input  logic [pcc_pkg::FRAC_W-1:0] frac,
  output logic [pcc_pkg::CHAN_W-1:0] chan
);

  logic                                     up;
  logic [pcc_pkg::CHAN_W-1:0]               diff;
  logic [pcc_pkg::CHAN_W+pcc_pkg::FRAC_W-1:0] prod;
  logic [pcc_pkg::CHAN_W-1:0]               step;

  // The step never exceeds the distance between the two entries, so the
  // result stays between them and needs no clamp.
  always_comb begin
    up   = (nxt >= cur);
    diff = up ? (nxt - cur) : (cur - nxt);
    prod = {{pcc_pkg::FRAC_W{1'b0}}, diff} * {{pcc_pkg::CHAN_W{1'b0}}, frac};
    step = prod[pcc_pkg::CHAN_W+pcc_pkg::FRAC_W-1:pcc_pkg::FRAC_W];
    chan = up ? (cur + step) : (cur - step);
  end

endmodule

### rtl/pcc_checker.sv
module pcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        tick_valid,
  input logic        tick_ready,
  input logic        color_valid,
  input logic        color_ready,
  input logic [31:0] color_word
);

  // A word waiting at the output holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |=> color_valid && $stable(color_word))
    else $error("color word changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !color_valid)
    else $error("color word valid right after reset");

  // A new word is only produced while the sequencer is busy with a tick.
  a_word_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(color_valid) |-> $past(!tick_ready))
    else $error("color word appeared while the block was idle");

  // The block only leaves idle because it took a tick.
  a_busy_from_tick: assert property (@(posedge clk) disable iff (rst)
    $fell(tick_ready) |-> $past(tick_valid))
    else $error("block went busy without taking a tick");

endmodule

bind palette_color_cycle pcc_checker u_pcc_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .color_valid (color.valid),
  .color_ready (color.ready),
  .color_word  ({color.red, color.green, color.blue, color.alpha})
);
